// File: sv/rigid_body_velocity_integrator_unit_macros.svh
// assertion macros for the velocity integrator checker
`ifndef RIGID_BODY_VELOCITY_INTEGRATOR_UNIT_MACROS_SVH
`define RIGID_BODY_VELOCITY_INTEGRATOR_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define RBVI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked outside reset
`define RBVI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: sv/rbvi_pkg.sv
// shared types and constants for the velocity integrator
package rbvi_pkg;
   localparam int unsigned DataWidth = 32;
   localparam int unsigned CfgWidth  = 31;
   localparam int unsigned DtWidth   = 16;
   localparam int unsigned IdxWidth  = 3;
   localparam int unsigned DefaultMass     = 65536;
   localparam int unsigned DefaultFriction = 13107200;
   localparam int unsigned DefaultMaxX     = 26214400;
   localparam int unsigned DefaultMaxY     = 78643200;

   localparam logic [IdxWidth-1:0] REG_MASS     = 3'd0;
   localparam logic [IdxWidth-1:0] REG_FRICTION = 3'd1;
   localparam logic [IdxWidth-1:0] REG_MAX_X    = 3'd2;
   localparam logic [IdxWidth-1:0] REG_MAX_Y    = 3'd3;
   localparam logic [IdxWidth-1:0] REG_KINEMATIC = 3'd4;

   localparam logic ACT_ADD_FORCE = 1'b0;
   localparam logic ACT_TICK      = 1'b1;

   typedef struct packed {
      logic                        action;
      logic signed [DataWidth-1:0] force_x;
      logic signed [DataWidth-1:0] force_y;
      logic [DtWidth-1:0]          frame_dt;
      logic signed [DataWidth-1:0] extra_accel_x;
      logic signed [DataWidth-1:0] extra_accel_y;
      logic signed [DataWidth-1:0] pos_in_x;
      logic signed [DataWidth-1:0] pos_in_y;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] pos_out_x;
      logic signed [DataWidth-1:0] pos_out_y;
      logic signed [DataWidth-1:0] vel_out_x;
      logic signed [DataWidth-1:0] vel_out_y;
   } rsp_type;

   typedef struct packed {
      logic [IdxWidth-1:0]  index;
      logic [DataWidth-1:0] data;
   } csr_type;

   // saturate a 34-bit signed value to 32 bits
   function automatic logic signed [DataWidth-1:0] sat34(input logic signed [33:0] v);
      logic signed [DataWidth-1:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

// File: sv/rbvi_if.sv
// valid/ready channel interfaces
interface rbvi_req_if;
   logic valid;
   logic ready;
   rbvi_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rbvi_rsp_if;
   logic valid;
   logic ready;
   rbvi_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rbvi_csr_if;
   logic valid;
   logic ready;
   rbvi_pkg::csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/rigid_body_velocity_integrator_unit.sv
// 2d semi-implicit euler velocity integrator, one shared iterative datapath
//  channel | dir | payload
//  req     | in  | action, force, frame_dt, extra accel, position
//  rsp     | out | new position, velocity
//  csr     | in  | register index, write data
// add_force is taken in idle without leaving it; a tick runs until the next accept through
// two force divides, the velocity update, the friction step, the square root and two shrink
// divides (root and shrinks skipped when the velocity is zero or friction stops the body),
// using the one-bit-per-cycle restoring divider and the two-bits-per-cycle square root.
// reset is synchronous and restores the register defaults and zero state.
// a result waits in its output register while new items are taken; a later tick
// holds in its last step until that register is free, which stalls the input.
module rigid_body_velocity_integrator_unit (
   input logic clock,
   input logic reset,
   rbvi_req_if.sink   req,
   rbvi_rsp_if.source rsp,
   rbvi_csr_if.sink   csr
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DIVX = 4'd1, S_DIVY = 4'd2,
      S_VEL = 4'd3, S_FRIC = 4'd4, S_SQRT = 4'd5, S_SHX = 4'd6,
      S_SHY = 4'd7, S_CLAMP = 4'd8, S_POS = 4'd9, S_OUT = 4'd10;

   // configuration
   logic [30:0] mass_ff, fric_ff, maxx_ff, maxy_ff;
   logic        kin_ff;
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= 31'(rbvi_pkg::DefaultMass);
         fric_ff <= 31'(rbvi_pkg::DefaultFriction);
         maxx_ff <= 31'(rbvi_pkg::DefaultMaxX);
         maxy_ff <= 31'(rbvi_pkg::DefaultMaxY);
         kin_ff  <= 1'b0;
      end else if (csr.valid) begin
         unique case (csr.payload.index)
            rbvi_pkg::REG_MASS:      mass_ff <= csr.payload.data[30:0];
            rbvi_pkg::REG_FRICTION:  fric_ff <= csr.payload.data[30:0];
            rbvi_pkg::REG_MAX_X:     maxx_ff <= csr.payload.data[30:0];
            rbvi_pkg::REG_MAX_Y:     maxy_ff <= csr.payload.data[30:0];
            rbvi_pkg::REG_KINEMATIC: kin_ff  <= csr.payload.data[0];
            default: ;
         endcase
      end
   end

   logic [3:0]  state_ff;
   logic [6:0]  cnt_ff;
   logic signed [31:0] fsx_ff, fsy_ff, vx_ff, vy_ff, ex_ff, ey_ff, px_ff, py_ff;
   logic [15:0] dt_ff;
   logic [31:0] fr_ff;     // friction amount
   // shared divider / root registers
   logic [63:0] num_ff, quo_ff;
   logic [63:0] rem_ff;
   logic [63:0] den_ff;
   logic [63:0] sq_ff;     // square root result
   logic        neg_ff;
   logic        stg_ff;    // which phase of a two-part step
   rbvi_pkg::rsp_type out_ff;
   logic        out_v_ff;
   logic        out_load;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_v_ff;
   assign rsp.payload = out_ff;
   assign out_load = (state_ff == S_OUT) && (!out_v_ff || rsp.ready);

   // one restoring divide step, remainders stay far below 2^63 so bit 64 is the borrow
   logic [64:0] rem_sh;
   logic [64:0] rem_sub;
   assign rem_sh  = {rem_ff, num_ff[63]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   // one square root step (two bits)
   logic [63:0] sq_bit, sq_trial;
   logic        root_first;
   assign sq_bit     = 64'd1 << {cnt_ff[4:0], 1'b0};
   assign sq_trial   = sq_ff + sq_bit;
   assign root_first = (cnt_ff == 7'd31);

   logic [31:0] mag_vx, mag_vy;
   assign mag_vx = vx_ff[31] ? 32'(-vx_ff) : vx_ff;
   assign mag_vy = vy_ff[31] ? 32'(-vy_ff) : vy_ff;

   // shared multiplier, one 32x17 signed product per cycle
   logic signed [31:0] mul_a;
   logic signed [48:0] mul_p;
   always_comb begin
      if (state_ff == S_VEL) mul_a = stg_ff ? ey_ff : ex_ff;
      else mul_a = stg_ff ? vy_ff : vx_ff;
   end
   assign mul_p = mul_a * $signed({1'b0, dt_ff});

   // signed quotient saturated to 32 bits
   logic signed [31:0] q_signed;
   always_comb begin
      if (!neg_ff)
         q_signed = (quo_ff > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(quo_ff[31:0]);
      else
         q_signed = (quo_ff >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-quo_ff[31:0]);
   end

   // friction shrink of one axis
   logic [31:0] shr_m;
   logic [31:0] shr_q;
   assign shr_m = (state_ff == S_SHX) ? mag_vx : mag_vy;
   assign shr_q = shr_m - quo_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         fsx_ff <= '0; fsy_ff <= '0; vx_ff <= '0; vy_ff <= '0;
      end else begin
         if (out_load) out_v_ff <= 1'b1;
         else if (rsp.ready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  if (req.payload.action == rbvi_pkg::ACT_ADD_FORCE) begin
                     if (!kin_ff) begin
                        fsx_ff <= rbvi_pkg::sat34(34'(fsx_ff) + 34'(req.payload.force_x));
                        fsy_ff <= rbvi_pkg::sat34(34'(fsy_ff) + 34'(req.payload.force_y));
                     end
                  end else begin
                     dt_ff <= req.payload.frame_dt;
                     ex_ff <= req.payload.extra_accel_x;
                     ey_ff <= req.payload.extra_accel_y;
                     px_ff <= req.payload.pos_in_x;
                     py_ff <= req.payload.pos_in_y;
                     neg_ff <= fsx_ff[31];
                     num_ff <= {(fsx_ff[31] ? 32'(-fsx_ff) : fsx_ff), 32'd0} >> 16;
                     den_ff <= {33'd0, (mass_ff == '0) ? 31'd1 : mass_ff};
                     rem_ff <= '0; quo_ff <= '0; cnt_ff <= 7'd64;
                     state_ff <= S_DIVX;
                  end
               end
            end
            S_DIVX, S_DIVY: begin
               if (cnt_ff != 0) begin
                  num_ff <= {num_ff[62:0], 1'b0};
                  if (!rem_sub[64]) begin
                     rem_ff <= rem_sub[63:0];
                     quo_ff <= {quo_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh[63:0];
                     quo_ff <= {quo_ff[62:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 7'd1;
               end else if (state_ff == S_DIVX) begin
                  ex_ff <= rbvi_pkg::sat34(34'(q_signed) + 34'(ex_ff));
                  neg_ff <= fsy_ff[31];
                  num_ff <= {(fsy_ff[31] ? 32'(-fsy_ff) : fsy_ff), 32'd0} >> 16;
                  rem_ff <= '0; quo_ff <= '0; cnt_ff <= 7'd64;
                  state_ff <= S_DIVY;
               end else begin
                  ey_ff <= rbvi_pkg::sat34(34'(q_signed) + 34'(ey_ff));
                  stg_ff <= 1'b0;
                  state_ff <= S_VEL;
               end
            end
            S_VEL: begin
               // velocity += accel*dt with floor shift
               if (!stg_ff) begin
                  vx_ff <= rbvi_pkg::sat34(34'(vx_ff) + 34'(mul_p >>> 16));
                  stg_ff <= 1'b1;
               end else begin
                  vy_ff <= rbvi_pkg::sat34(34'(vy_ff) + 34'(mul_p >>> 16));
                  state_ff <= S_FRIC;
               end
            end
            S_FRIC: begin
               fr_ff <= 32'((47'(fric_ff) * 47'(dt_ff)) >> 16);
               state_ff <= S_SQRT;
               stg_ff <= 1'b0;
               num_ff <= 64'(mag_vx) * 64'(mag_vx);
               sq_ff <= '0;
               cnt_ff <= 7'd31;
            end
            S_SQRT: begin
               if (!stg_ff) begin
                  // finish s2 = vx^2 + vy^2
                  num_ff <= num_ff + 64'(mag_vy) * 64'(mag_vy);
                  stg_ff <= 1'b1;
               end else if (root_first && num_ff == 0) begin
                  state_ff <= S_CLAMP;
               end else if (root_first && num_ff <= 64'(fr_ff) * 64'(fr_ff)) begin
                  vx_ff <= '0; vy_ff <= '0;
                  state_ff <= S_CLAMP;
               end else begin
                  // isqrt step
                  if (num_ff >= sq_trial) begin
                     num_ff <= num_ff - sq_trial;
                     sq_ff <= (sq_ff >> 1) + sq_bit;
                  end else begin
                     sq_ff <= sq_ff >> 1;
                  end
                  if (cnt_ff == 0) begin
                     // start shrink of x: |vx|*f / s
                     cnt_ff <= 7'd64;
                     state_ff <= S_SHX;
                     stg_ff <= 1'b0;
                  end else begin
                     cnt_ff <= cnt_ff - 7'd1;
                  end
               end
            end
            S_SHX, S_SHY: begin
               if (!stg_ff) begin
                  num_ff <= 64'(shr_m) * 64'(fr_ff);
                  den_ff <= sq_ff;
                  rem_ff <= '0; quo_ff <= '0; cnt_ff <= 7'd64;
                  stg_ff <= 1'b1;
               end else if (cnt_ff != 0) begin
                  num_ff <= {num_ff[62:0], 1'b0};
                  if (!rem_sub[64]) begin
                     rem_ff <= rem_sub[63:0];
                     quo_ff <= {quo_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh[63:0];
                     quo_ff <= {quo_ff[62:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 7'd1;
               end else begin
                  stg_ff <= 1'b0;
                  if (state_ff == S_SHX) begin
                     vx_ff <= vx_ff[31] ? 32'(-shr_q) : shr_q;
                     state_ff <= S_SHY;
                  end else begin
                     vy_ff <= vy_ff[31] ? 32'(-shr_q) : shr_q;
                     state_ff <= S_CLAMP;
                  end
               end
            end
            S_CLAMP: begin
               if (32'(mag_vx) > 32'(maxx_ff))
                  vx_ff <= vx_ff[31] ? 32'(-{1'b0, maxx_ff}) : {1'b0, maxx_ff};
               if (32'(mag_vy) > 32'(maxy_ff))
                  vy_ff <= vy_ff[31] ? 32'(-{1'b0, maxy_ff}) : {1'b0, maxy_ff};
               stg_ff <= 1'b0;
               state_ff <= S_POS;
            end
            S_POS: begin
               // new position kept in the position registers
               if (!stg_ff) begin
                  px_ff <= rbvi_pkg::sat34(34'(px_ff) + 34'(mul_p >>> 16));
                  stg_ff <= 1'b1;
               end else begin
                  py_ff <= rbvi_pkg::sat34(34'(py_ff) + 34'(mul_p >>> 16));
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // wait until the output register is free
               if (out_load) begin
                  out_ff.pos_out_x <= px_ff;
                  out_ff.pos_out_y <= py_ff;
                  out_ff.vel_out_x <= vx_ff;
                  out_ff.vel_out_y <= vy_ff;
                  fsx_ff <= '0; fsy_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: sv/rbvi_checker.sv
// port-level checks for the velocity integrator
`include "rigid_body_velocity_integrator_unit_macros.svh"
module rbvi_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_action,
   input logic rsp_valid,
   input logic rsp_ready
);
   // accepted beats by kind
   logic tick_take, force_take;
   assign tick_take  = req_valid && req_ready && req_action;
   assign force_take = req_valid && req_ready && !req_action && !rsp_valid;

   `RBVI_ASSERT_IMPL(a_known, clock, reset, 1'b1, !$isunknown({req_ready, rsp_valid}), "x out")
   `RBVI_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `RBVI_ASSERT_NEXT(a_tick_busy, clock, reset, tick_take, !req_ready, "ready during tick")
   `RBVI_ASSERT_NEXT(a_force_no_rsp, clock, reset, force_take, !rsp_valid, "add_force result")
endmodule

bind rigid_body_velocity_integrator_unit rbvi_checker u_rbvi_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_action(req.payload.action),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);

// File: test/tb_rigid_body_velocity_integrator_unit.sv
// testbench for the 2d velocity integrator: random and directed beats with a scoreboard
`timescale 1ns / 100ps

module tb_rigid_body_velocity_integrator_unit;

   // drain time after the last result
   localparam int SettleCycles = 250;

   logic clock;
   logic reset;

   rbvi_req_if req ();
   rbvi_rsp_if rsp ();
   rbvi_csr_if csr ();

   rigid_body_velocity_integrator_unit uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // predicts integrator results and checks them in order
   class motion_scoreboard;
      longint            force_sum_x, force_sum_y;
      longint            vel_x, vel_y;
      longint unsigned   mass, friction, limit_x, limit_y;
      bit                kinematic;
      rbvi_pkg::rsp_type pending_motion[$];
      int                mismatches;

      function new();
         mass = rbvi_pkg::DefaultMass;
         friction = rbvi_pkg::DefaultFriction;
         limit_x = rbvi_pkg::DefaultMaxX;
         limit_y = rbvi_pkg::DefaultMaxY;
         kinematic = 1'b0;
         force_sum_x = 0;
         force_sum_y = 0;
         vel_x = 0;
         vel_y = 0;
         mismatches = 0;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : longint'(v);
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint accel_from_force(longint fsum, longint unsigned m);
         longint unsigned q;
         q = (magnitude(fsum) << 16) / m;
         return sat32((fsum < 0) ? -longint'(q) : longint'(q));
      endfunction

      function longint shrink(longint v, longint unsigned f, longint unsigned s);
         longint unsigned m, r;
         m = magnitude(v);
         r = m - (m * f) / s;
         return (v < 0) ? -longint'(r) : longint'(r);
      endfunction

      function longint clamp(longint v, longint unsigned lim);
         if (magnitude(v) > lim) return (v < 0) ? -longint'(lim) : longint'(lim);
         return v;
      endfunction

      function void write_reg(logic [rbvi_pkg::IdxWidth-1:0] idx,
                              logic [rbvi_pkg::DataWidth-1:0] data);
         case (idx)
            rbvi_pkg::REG_MASS: mass = 64'(data[30:0]);
            rbvi_pkg::REG_FRICTION: friction = 64'(data[30:0]);
            rbvi_pkg::REG_MAX_X: limit_x = 64'(data[30:0]);
            rbvi_pkg::REG_MAX_Y: limit_y = 64'(data[30:0]);
            rbvi_pkg::REG_KINEMATIC: kinematic = data[0];
            default: ;
         endcase
      endfunction

      // one accepted input beat
      function void note_input(rbvi_pkg::req_type it);
         longint            ax, ay, vx, vy, dt;
         longint unsigned   m, f, s2, s;
         rbvi_pkg::rsp_type res;
         if (it.action == rbvi_pkg::ACT_ADD_FORCE) begin
            if (!kinematic) begin
               force_sum_x = sat32(force_sum_x + longint'($signed(it.force_x)));
               force_sum_y = sat32(force_sum_y + longint'($signed(it.force_y)));
            end
            return;
         end
         dt = longint'(it.frame_dt);
         m = (mass == 0) ? 1 : mass;
         ax = sat32(accel_from_force(force_sum_x, m) + longint'($signed(it.extra_accel_x)));
         ay = sat32(accel_from_force(force_sum_y, m) + longint'($signed(it.extra_accel_y)));
         vx = sat32(vel_x + ((ax * dt) >>> 16));
         vy = sat32(vel_y + ((ay * dt) >>> 16));
         // coulomb friction against the velocity direction
         f = (friction * longint'(dt)) >> 16;
         s2 = magnitude(vx) * magnitude(vx) + magnitude(vy) * magnitude(vy);
         if (s2 != 0) begin
            if (s2 <= f * f) begin
               vx = 0;
               vy = 0;
            end else begin
               s = int_sqrt(s2);
               vx = shrink(vx, f, s);
               vy = shrink(vy, f, s);
            end
         end
         vx = clamp(vx, limit_x);
         vy = clamp(vy, limit_y);
         vel_x = vx;
         vel_y = vy;
         res.pos_out_x = 32'(sat32(longint'($signed(it.pos_in_x)) + ((vx * dt) >>> 16)));
         res.pos_out_y = 32'(sat32(longint'($signed(it.pos_in_y)) + ((vy * dt) >>> 16)));
         res.vel_out_x = 32'(vx);
         res.vel_out_y = 32'(vy);
         pending_motion.push_back(res);
         force_sum_x = 0;
         force_sum_y = 0;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
         mismatches++;
      endtask

      // one accepted result beat
      task check_result(rbvi_pkg::rsp_type got);
         rbvi_pkg::rsp_type want;
         if (pending_motion.size() == 0) begin
            report_mismatch("unexpected result", got.vel_out_x, 32'h0);
            return;
         end
         want = pending_motion.pop_front();
         if (got.pos_out_x !== want.pos_out_x)
            report_mismatch("pos_out_x", got.pos_out_x, want.pos_out_x);
         if (got.pos_out_y !== want.pos_out_y)
            report_mismatch("pos_out_y", got.pos_out_y, want.pos_out_y);
         if (got.vel_out_x !== want.vel_out_x)
            report_mismatch("vel_out_x", got.vel_out_x, want.vel_out_x);
         if (got.vel_out_y !== want.vel_out_y)
            report_mismatch("vel_out_y", got.vel_out_y, want.vel_out_y);
      endtask
   endclass

   motion_scoreboard motion;
   bit quiet;
   int hold_request;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #40ms;
      $display("tb_rigid_body_velocity_integrator_unit: done, errors");
      $finish;
   end

   // result side: random stalls plus requested long holds
   initial begin : result_side
      int stall_left;
      stall_left = 0;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) motion.check_result(rsp.payload);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else if (quiet) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= 1'b1;
            case ($urandom_range(0, 99)) inside
               [0:24]: stall_left = $urandom_range(1, 3);
               [25:27]: stall_left = $urandom_range(15, 60);
               default: ;
            endcase
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // signed q16.16 value, often moderate, sometimes extreme or fully random
   function automatic logic [31:0] pick_value(int bits);
      logic [31:0] v;
      case ($urandom_range(0, 15))
         0: v = 32'h0;
         1: v = 32'h7FFF_FFFF;
         2: v = 32'h8000_0000;
         3: v = 32'hFFFF_FFFF;
         4, 5: v = $urandom;
         default: begin
            v = $urandom & ((32'h1 << bits) - 1);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_dt();
      case ($urandom_range(0, 7))
         0: return 16'h0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom);
         default: return 16'($urandom_range(200, 4000));
      endcase
   endfunction

   function automatic rbvi_pkg::req_type random_beat();
      rbvi_pkg::req_type it;
      it.action = ($urandom_range(0, 99) < 45) ? rbvi_pkg::ACT_ADD_FORCE : rbvi_pkg::ACT_TICK;
      it.force_x = pick_value(24);
      it.force_y = pick_value(24);
      it.frame_dt = pick_dt();
      it.extra_accel_x = pick_value(24);
      it.extra_accel_y = pick_value(24);
      it.pos_in_x = pick_value(28);
      it.pos_in_y = pick_value(28);
      return it;
   endfunction

   // offer one input beat, valid stays high unless a gap comes next time
   task send_beat(rbvi_pkg::req_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= it;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      motion.note_input(it);
   endtask

   // stop offering and wait until every expected result has come
   task drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (motion.pending_motion.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task write_reg(logic [rbvi_pkg::IdxWidth-1:0] idx, logic [rbvi_pkg::DataWidth-1:0] data);
      csr.valid <= 1'b1;
      csr.payload <= '{index: idx, data: data};
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      motion.write_reg(idx, data);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task configure(logic [31:0] m, logic [31:0] fr, logic [31:0] lx, logic [31:0] ly,
                  logic [31:0] kin);
      drain();
      write_reg(rbvi_pkg::REG_MASS, m);
      write_reg(rbvi_pkg::REG_FRICTION, fr);
      write_reg(rbvi_pkg::REG_MAX_X, lx);
      write_reg(rbvi_pkg::REG_MAX_Y, ly);
      write_reg(rbvi_pkg::REG_KINEMATIC, kin);
   endtask

   function automatic rbvi_pkg::req_type make_beat(logic act, logic [31:0] fx,
                                                   logic [31:0] fy, logic [15:0] dt,
                                                   logic [31:0] ex, logic [31:0] ey,
                                                   logic [31:0] px, logic [31:0] py);
      rbvi_pkg::req_type it;
      it.action = act;
      it.force_x = fx;
      it.force_y = fy;
      it.frame_dt = dt;
      it.extra_accel_x = ex;
      it.extra_accel_y = ey;
      it.pos_in_x = px;
      it.pos_in_y = py;
      return it;
   endfunction

   task random_phase(int count, bit with_hold, bit with_pause);
      quiet = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i == 60) quiet = 1'b0;
         if (with_hold && i == count / 3) hold_request = 1000;
         if (with_pause && i == count / 2) drain();
         send_beat(random_beat());
      end
      quiet = 1'b0;
   endtask

   // stimulus
   initial begin
      motion = new();
      quiet = 1'b0;
      hold_request = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.payload = '0;
      csr.valid = 1'b0;
      csr.payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats at reset settings
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'd1000, 0, 0, 0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'hFFFF, 32'h0100_0000, 32'hFF00_0000,
                          0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_ADD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0,
                          0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_ADD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'hFFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF));
      send_beat(make_beat(rbvi_pkg::ACT_ADD_FORCE, 32'h0003_0000, 32'hFFFD_0000, 0, 0, 0,
                          0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'd1092, 32'h0001_0000, 0,
                          32'h0010_0000, 32'hFFF0_0000));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'd1092, 0, 0, 0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'd30000, 0, 0, 0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_ADD_FORCE, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0,
                          0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'd1, 0, 0, 32'h1234_5678,
                          32'hEDCB_A987));

      // zero mass, no friction, wide limits
      configure(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
      send_beat(make_beat(rbvi_pkg::ACT_ADD_FORCE, 32'h0000_8000, 32'hFFFF_8000, 0, 0, 0,
                          0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'd6000, 0, 0, 0, 0));
      random_phase(300, 1'b0, 1'b0);

      // heavy body, maximum friction, zero limits, kinematic
      configure(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1);
      send_beat(make_beat(rbvi_pkg::ACT_ADD_FORCE, 32'h0100_0000, 32'h0100_0000, 0, 0, 0,
                          0, 0));
      send_beat(make_beat(rbvi_pkg::ACT_TICK, 0, 0, 16'd1000, 32'h0001_0000, 0, 0, 0));
      random_phase(300, 1'b1, 1'b0);

      // mass of one, modest friction and limits
      configure(32'h1, 32'h0001_0000, 32'h0064_0000, 32'h00C8_0000, 32'h0);
      random_phase(300, 1'b0, 1'b1);

      // fully random settings
      for (int p = 0; p < 3; p++) begin
         configure($urandom, $urandom & 32'h0FFF_FFFF, $urandom, $urandom, $urandom);
         random_phase(300, p == 1, p == 2);
      end

      // back to reset values
      configure(rbvi_pkg::DefaultMass, rbvi_pkg::DefaultFriction, rbvi_pkg::DefaultMaxX,
                rbvi_pkg::DefaultMaxY, 32'h0);
      random_phase(100, 1'b0, 1'b0);

      drain();
      if (motion.mismatches == 0)
         $display("tb_rigid_body_velocity_integrator_unit: done, clean");
      else
         $display("tb_rigid_body_velocity_integrator_unit: done, errors");
      $finish;
   end
endmodule
